[hdl/bcpe_pkg.sv]
`timescale 1ns / 1ps
package bcpe_pkg;

	localparam int MAX_POINTS_DEF  = 4;
	localparam int COORD_WIDTH_DEF = 16;
	localparam int T_FRAC_BITS_DEF = 16;

	localparam int CNT_W = 3;
	localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(4);

	// register map, one 64-bit slot per register
	localparam int REG_POINT_COUNT = 0;
	localparam int REG_CTRL_BASE   = 1;
	localparam int REG_SLOT_BYTES  = 8;
	localparam int REG_DATA_W      = 64;

endpackage

[hdl/bcpe_lerp.sv]
`timescale 1ns / 1ps
module bcpe_lerp #(
	parameter int COORD_WIDTH = 16,
	parameter int T_FRAC_BITS = 16
) (
	input  logic signed [COORD_WIDTH-1:0] a,
	input  logic signed [COORD_WIDTH-1:0] b,
	input  logic        [T_FRAC_BITS:0]   t,
	output logic signed [COORD_WIDTH-1:0] y
);

	localparam int PW = COORD_WIDTH + T_FRAC_BITS + 2;

	logic signed [COORD_WIDTH:0]   diff;
	logic signed [T_FRAC_BITS+1:0] t_sgn;
	logic signed [PW-1:0]          prod;
	logic signed [PW-1:0]          rnd;

	// a + floor(((b - a) * t + half) / 2^T); the quotient is cut to COORD_WIDTH bits before the add
	always_comb begin
		diff  = {b[COORD_WIDTH-1], b} - {a[COORD_WIDTH-1], a};
		t_sgn = {1'b0, t};
		prod  = PW'(diff) * PW'(t_sgn);
		rnd   = prod + PW'({1'b1, {(T_FRAC_BITS-1){1'b0}}});
		y     = a + rnd[T_FRAC_BITS +: COORD_WIDTH];
	end

endmodule

[hdl/bezier_curve_point_eval_top.sv]
`timescale 1ns / 1ps
// Pipeline: one capture stage, then one register stage per de Casteljau round
// (MAX_POINTS-1 rounds) between an accepted t word and its result word.
// Throughput: one word per cycle; a stage holds only while it and every stage
// after it are full and out_stall is high.
// Reset: point_count = 4, control points = 0, pipeline empty.
module bezier_curve_point_eval_top
	import bcpe_pkg::*;
#(
	parameter int MAX_POINTS  = MAX_POINTS_DEF,
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int T_FRAC_BITS = T_FRAC_BITS_DEF,
	localparam int ADDR_W     = $clog2(REG_SLOT_BYTES * (MAX_POINTS + 1))
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ADDR_W-1:0]             paddr,
	input  logic [REG_DATA_W-1:0]         pwdata,
	output logic [REG_DATA_W-1:0]         prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [T_FRAC_BITS:0]          t_pos,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] pos_x,
	output logic signed [COORD_WIDTH-1:0] pos_y,
	output logic signed [COORD_WIDTH-1:0] pos_z
);

	localparam int NST   = MAX_POINTS;
	localparam int RND   = MAX_POINTS - 1;
	localparam int PT_W  = 3 * COORD_WIDTH;
	localparam int IDX_W = ADDR_W - $clog2(REG_SLOT_BYTES);
	localparam logic [T_FRAC_BITS:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

	// configuration
	logic [CNT_W-1:0] point_count_q;
	logic [PT_W-1:0]  ctrl_q [MAX_POINTS];
	logic [IDX_W-1:0] reg_idx;
	logic             cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1 -: IDX_W];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= CNT_RESET;
			for (int k = 0; k < MAX_POINTS; k++) ctrl_q[k] <= '0;
		end else if (cfg_wr) begin
			if (reg_idx == IDX_W'(REG_POINT_COUNT)) point_count_q <= pwdata[CNT_W-1:0];
			for (int k = 0; k < MAX_POINTS; k++) begin
				if (reg_idx == IDX_W'(REG_CTRL_BASE + k)) ctrl_q[k] <= pwdata[PT_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == IDX_W'(REG_POINT_COUNT)) prdata = REG_DATA_W'(point_count_q);
		for (int k = 0; k < MAX_POINTS; k++) begin
			if (reg_idx == IDX_W'(REG_CTRL_BASE + k)) prdata = REG_DATA_W'(ctrl_q[k]);
		end
	end

	// pipeline: stage 0 captures, stage r holds the points after round r
	logic [NST-1:0]                vld_s;
	logic [NST-1:0]                en;
	logic [T_FRAC_BITS:0]          t_s   [NST];
	logic [RND-1:0]                act_s [NST];
	logic signed [COORD_WIDTH-1:0] pt_s  [NST][MAX_POINTS][3];

	always_comb begin
		en[NST-1] = !vld_s[NST-1] || !out_stall;
		for (int k = NST - 2; k >= 0; k--) en[k] = !vld_s[k] || en[k+1];
	end

	assign in_stall = !en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) vld_s[0] <= in_valid;
			for (int k = 1; k < NST; k++) begin
				if (en[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			t_s[0] <= t_pos[T_FRAC_BITS] ? T_ONE : t_pos;
			for (int j = 0; j < RND; j++) act_s[0][j] <= point_count_q > CNT_W'(j + 1);
			for (int k = 0; k < MAX_POINTS; k++) begin
				for (int c = 0; c < 3; c++) begin
					pt_s[0][k][c] <= ctrl_q[k][c*COORD_WIDTH +: COORD_WIDTH];
				end
			end
		end
	end

	genvar r, i, c;
	generate
		for (r = 1; r < NST; r++) begin : g_round
			always_ff @(posedge clk) begin
				if (en[r]) begin
					t_s[r]   <= t_s[r-1];
					act_s[r] <= act_s[r-1];
				end
			end
			for (i = 0; i < MAX_POINTS - r; i++) begin : g_pt
				for (c = 0; c < 3; c++) begin : g_ax
					logic signed [COORD_WIDTH-1:0] mix;
					bcpe_lerp #(
						.COORD_WIDTH(COORD_WIDTH),
						.T_FRAC_BITS(T_FRAC_BITS)
					) u_lerp (
						.a(pt_s[r-1][i][c]),
						.b(pt_s[r-1][i+1][c]),
						.t(t_s[r-1]),
						.y(mix)
					);
					always_ff @(posedge clk) begin
						if (en[r]) pt_s[r][i][c] <= act_s[r-1][r-1] ? mix : pt_s[r-1][i][c];
					end
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[NST-1];
	assign pos_x     = pt_s[NST-1][0][0];
	assign pos_y     = pt_s[NST-1][0][1];
	assign pos_z     = pt_s[NST-1][0][2];

	// checks
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> &vld_s)
		else $error("input stalled with an empty stage");

	a_t_sat: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] |-> t_s[0] <= T_ONE)
		else $error("captured t above one");

	a_act_thermo: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] |-> ((act_s[0] + RND'(1)) & act_s[0]) == '0)
		else $error("round enables not contiguous");

	generate
		for (r = 1; r < NST; r++) begin : g_chk
			a_idle_round: assert property (@(posedge clk) disable iff (!arst_n)
				en[r] && vld_s[r-1] && !act_s[r-1][r-1]
				|=> pt_s[r][0][0] == $past(pt_s[r-1][0][0]))
				else $error("inactive round changed the point");
		end
	endgenerate

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
module testbench;
	import bcpe_pkg::*;

	localparam int NPTS = MAX_POINTS_DEF;
	localparam int CW = COORD_WIDTH_DEF;
	localparam int TFB = T_FRAC_BITS_DEF;
	localparam int ADDR_W = $clog2(REG_SLOT_BYTES * (NPTS + 1));
	localparam logic [TFB:0] T_END = 1 << TFB;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RAND_PHASES = 13;
	localparam int PHASE_WORDS = 100;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} point_t;

	typedef struct {
		int cnt;
		int t;
		bit known;
		point_t pt;
	} dir_row_t;

	localparam point_t P0 = '{16'h8000, 16'h7fff, 16'h0000};
	localparam point_t P1 = '{16'h7fff, 16'h8000, 16'hffff};
	localparam point_t P2 = '{16'h8000, 16'h8000, 16'h7fff};
	localparam point_t P3 = '{16'h7fff, 16'h7fff, 16'h8000};
	localparam point_t ZERO = '0;

	point_t dir_pts[NPTS] = '{P0, P1, P2, P3};

	// count, t, expected known, expected point
	dir_row_t dir_rows[23] = '{
		'{4, 0,      1, P0},
		'{4, 65536,  1, P3},
		'{4, 131071, 1, P3},
		'{4, 65537,  1, P3},
		'{4, 1,      0, ZERO},
		'{4, 32768,  0, ZERO},
		'{4, 65535,  0, ZERO},
		'{4, 21845,  0, ZERO},
		'{4, 98304,  1, P3},
		'{3, 65536,  1, P2},
		'{3, 0,      1, P0},
		'{3, 40000,  0, ZERO},
		'{2, 65536,  1, P1},
		'{2, 32768,  0, ZERO},
		'{2, 12345,  0, ZERO},
		'{1, 50000,  1, P0},
		'{1, 131071, 1, P0},
		'{0, 65536,  1, P0},
		'{0, 777,    1, P0},
		'{7, 65536,  1, P3},
		'{7, 0,      1, P0},
		'{5, 30000,  0, ZERO},
		'{6, 65536,  1, P3}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [REG_DATA_W-1:0] pwdata = '0;
	logic [REG_DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [TFB:0] t_pos = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [CW-1:0] pos_x;
	logic signed [CW-1:0] pos_y;
	logic signed [CW-1:0] pos_z;

	logic [2:0] cfg_count = CNT_RESET;
	logic [3*CW-1:0] cfg_pt[NPTS] = '{default: '0};

	point_t expected_points[$];
	int idle_pct = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	int errors = 0;
	int mismatches = 0;
	point_t seen;
	point_t want;

	bezier_curve_point_eval_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.t_pos(t_pos),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// de Casteljau with round-half-up lerp, t clamped to one
	function automatic point_t curve_point(input logic [TFB:0] t_in);
		longint signed p[NPTS][3];
		longint signed tt;
		int n;
		point_t r;
		tt = (t_in > T_END) ? longint'(T_END) : longint'(t_in);
		n = int'(cfg_count);
		if (n < 1)
			n = 1;
		if (n > NPTS)
			n = NPTS;
		for (int k = 0; k < n; k++)
			for (int c = 0; c < 3; c++)
				p[k][c] = longint'($signed(cfg_pt[k][c*CW +: CW]));
		for (int rd = 1; rd < n; rd++)
			for (int i = 0; i < n - rd; i++)
				for (int c = 0; c < 3; c++)
					p[i][c] = p[i][c]
						+ (((p[i+1][c] - p[i][c]) * tt + (longint'(1) << (TFB - 1))) >>> TFB);
		r.x = p[0][0][CW-1:0];
		r.y = p[0][1][CW-1:0];
		r.z = p[0][2][CW-1:0];
		return r;
	endfunction

	function automatic logic [REG_DATA_W-1:0] pack_point(input point_t pt);
		logic [15:0] junk;
		junk = 16'($urandom);
		return {junk, pt.z, pt.y, pt.x};
	endfunction

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return CW'($urandom);
		endcase
	endfunction

	function automatic logic [TFB:0] rand_t();
		case ($urandom_range(0, 9))
			0: return T_END;
			1: return '0;
			2: return (TFB+1)'($urandom_range(int'(T_END) + 1, (1 << (TFB + 1)) - 1));
			3: return (TFB+1)'($urandom);
			default: return (TFB+1)'($urandom_range(0, int'(T_END)));
		endcase
	endfunction

	task automatic cfg_write(input int idx, input logic [REG_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * REG_SLOT_BYTES);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_POINT_COUNT)
			cfg_count = data[2:0];
		else if (idx >= REG_CTRL_BASE && idx < REG_CTRL_BASE + NPTS)
			cfg_pt[idx - REG_CTRL_BASE] = data[3*CW-1:0];
		@(posedge clk);
	endtask

	task automatic write_count(input int cnt);
		logic [REG_DATA_W-1:0] v;
		v = {$urandom, $urandom};
		v[2:0] = cnt[2:0];
		cfg_write(REG_POINT_COUNT, v);
	endtask

	task automatic send_word(input logic [TFB:0] t, input bit known, input point_t pt);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		t_pos <= t;
		do @(posedge clk); while (in_stall);
		expected_points.insert(expected_points.size(), known ? pt : curve_point(t));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (2 * NPTS) @(posedge clk);
	endtask

	// output check and stall generation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen = '{pos_x, pos_y, pos_z};
			if (expected_points.size() == 0) begin
				errors++;
				if (mismatches++ < 10)
					$display("unexpected word x=%0d y=%0d z=%0d", pos_x, pos_y, pos_z);
			end else begin
				want = expected_points.pop_front();
				if (seen.x !== want.x || seen.y !== want.y || seen.z !== want.z) begin
					errors++;
					if (mismatches++ < 10)
						$display("mismatch: exp x=%0d y=%0d z=%0d got x=%0d y=%0d z=%0d",
							want.x, want.y, want.z, seen.x, seen.y, seen.z);
				end
			end
		end
		if (idle_pct == 0) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if ($urandom_range(0, 99) < idle_pct) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 3);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles = 0;
		end else if (++idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int cur_cnt;
		int pct_pick[3];
		point_t cp;
		pct_pick = '{0, 15, 40};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state: every control point zero
		send_word(17'd43210, 1'b1, ZERO);
		drain();
		for (int k = 0; k < NPTS; k++)
			cfg_write(REG_CTRL_BASE + k, pack_point(dir_pts[k]));
		// slot past the last control point: write must be dropped
		cfg_write(REG_CTRL_BASE + NPTS, {REG_DATA_W{1'b1}});
		cur_cnt = int'(CNT_RESET);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].cnt != cur_cnt) begin
				drain();
				write_count(dir_rows[i].cnt);
				cur_cnt = dir_rows[i].cnt;
			end
			send_word((TFB+1)'(dir_rows[i].t), dir_rows[i].known, dir_rows[i].pt);
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain();
			if ($urandom_range(0, 9) < 8)
				write_count($urandom_range(1, NPTS));
			else
				write_count($urandom_range(0, 7));
			for (int k = 0; k < NPTS; k++) begin
				cp = '{rand_coord(), rand_coord(), rand_coord()};
				cfg_write(REG_CTRL_BASE + k, pack_point(cp));
			end
			idle_pct = (ph == RAND_PHASES - 1) ? 0 : pct_pick[$urandom_range(0, 2)];
			repeat (PHASE_WORDS) send_word(rand_t(), 1'b0, ZERO);
		end
		drain();

		if (expected_points.size() != 0)
			errors++;
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[sim.f]
hdl/bcpe_pkg.sv
hdl/bcpe_lerp.sv
hdl/bezier_curve_point_eval_top.sv
tb/sv/testbench.sv
